[hw/rtl/mnmf_pkg.sv]
`timescale 1ns / 1ps

package mnmf_pkg;

    // Grid limits and field widths.
    localparam int MAX_COLS   = 32;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int PROB_W     = 16;
    localparam int CELL_W     = PROB_W + 1;
    localparam int COLS_CFG_W = 6;
    localparam int ROWS_CFG_W = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int COLS_RESET = 32;
    localparam int ROWS_RESET = 32;

    // Mean arithmetic: a sum of up to nine Q0.16 values and a count of 1 to 9.
    localparam int SUM_W   = 20;
    localparam int CNT_W   = 4;
    localparam int FRAC_W  = 20;
    localparam int RECIP_W = FRAC_W + 1;
    localparam int RECIP_ONE = 1 << FRAC_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_FIX,
        S_FRD,
        S_FSH
    } t_state;

    // Which neighborhood the mean unit works on: a row result for the column
    // behind the newest one, the extra result at the right edge, and the same
    // two kinds while the final row is flushed.
    typedef enum logic [1:0] {
        JOB_ROW_A,
        JOB_ROW_B,
        JOB_FL_A,
        JOB_FL_B
    } t_job;

    typedef struct packed {
        logic [8:0]             sel;
        logic [8:0][PROB_W-1:0] val;
    } t_nbhd;

    typedef struct packed {
        logic              valid;
        logic [PROB_W-1:0] mean;
    } t_mean_res;

    // floor(2^FRAC_W / d); with sums below 2^FRAC_W the product is at most one low.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd1:    m = RECIP_W'(RECIP_ONE);
            4'd2:    m = RECIP_W'(RECIP_ONE / 2);
            4'd3:    m = RECIP_W'(RECIP_ONE / 3);
            4'd4:    m = RECIP_W'(RECIP_ONE / 4);
            4'd5:    m = RECIP_W'(RECIP_ONE / 5);
            4'd6:    m = RECIP_W'(RECIP_ONE / 6);
            4'd7:    m = RECIP_W'(RECIP_ONE / 7);
            4'd8:    m = RECIP_W'(RECIP_ONE / 8);
            4'd9:    m = RECIP_W'(RECIP_ONE / 9);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/masked_neighborhood_mean_filter_top.sv]
// Masked 3x3 mean filter over a raster stream of grid cells. Each accepted item
// is one cell (probability and traversable flag); results are the truncated
// mean of the traversable in-grid neighbors of a cell, or 0 for a cell that is
// not traversable, tagged with row and column. The result for cell (r-1, c-1)
// leaves after cell (r, c) arrives, the last cell of a row also emits (r-1, c),
// and the last cell of the frame flushes the final row. The block takes one
// item at a time: a cell does a read-modify-write of the line store entry of
// its column, and each result it causes goes through the reciprocal-multiply
// mean unit; the frame's last cell then flushes each column (a line store
// read, and a mean where it yields a result). A waiting result stalls the
// block only when the next result is ready. Writing either size register
// restarts the frame at cell (0,0); the line store needs no clearing after reset.
`timescale 1ns / 1ps

module masked_neighborhood_mean_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mnmf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mnmf_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mnmf_pkg::PROB_W-1:0]       i_prob_in,
    input  logic                              i_traversable,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mnmf_pkg::PROB_W-1:0]       o_prob_out,
    output logic [mnmf_pkg::ROW_W-1:0]        o_out_row,
    output logic [mnmf_pkg::COL_W-1:0]        o_out_col,
    output logic                              o_last_of_run,
    output logic                              o_end_of_frame
);

    localparam int COL_W  = mnmf_pkg::COL_W;
    localparam int ROW_W  = mnmf_pkg::ROW_W;
    localparam int CELL_W = mnmf_pkg::CELL_W;
    localparam int ENT_W  = 2 * CELL_W;

    mnmf_pkg::t_state r_state, n_state;
    mnmf_pkg::t_job   r_job, n_job;

    logic [COL_W-1:0]  r_last_col;
    logic [ROW_W-1:0]  r_last_row;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_pos, n_pos;
    logic [ROW_W-1:0]  r_r;
    logic [CELL_W-1:0] r_cur;
    logic              r_at_lcol;
    logic              r_at_end;
    logic [CELL_W-1:0] r_win [3][3];

    // Line store: one entry per column, {row before previous, previous row}.
    logic [ENT_W-1:0]  mem [mnmf_pkg::MAX_COLS];
    logic [ENT_W-1:0]  r_rdata;

    logic                      r_ovalid;
    logic [mnmf_pkg::PROB_W-1:0] r_oprob;
    logic [ROW_W-1:0]          r_orow;
    logic [COL_W-1:0]          r_ocol;
    logic                      r_olast;
    logic                      r_oeof;

    logic              in_acc;
    logic              cfg_hit;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic              wr_en;
    logic              shift;
    logic              flush_col;
    logic              start;
    logic              out_load;
    logic              out_free;
    logic              is_b;
    logic              is_fl;
    logic [2:0]        vr;
    logic [2:0]        vc;
    mnmf_pkg::t_nbhd     nbhd;
    mnmf_pkg::t_mean_res mres;

    logic [mnmf_pkg::COLS_CFG_W-1:0] cfg_cols;
    logic [mnmf_pkg::ROWS_CFG_W-1:0] cfg_rows;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_hit  = i_cfg_we && (i_cfg_idx == mnmf_pkg::REG_GRID_COLS ||
                                   i_cfg_idx == mnmf_pkg::REG_GRID_ROWS);
    assign out_free = !r_ovalid || i_out_ready;
    assign cfg_cols = i_cfg_data[mnmf_pkg::COLS_CFG_W-1:0];
    assign cfg_rows = i_cfg_data[mnmf_pkg::ROWS_CFG_W-1:0];

    // Sizes are kept as last index; zero acts as one and large values saturate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= COL_W'(mnmf_pkg::COLS_RESET - 1);
            r_last_row <= ROW_W'(mnmf_pkg::ROWS_RESET - 1);
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mnmf_pkg::REG_GRID_COLS: begin
                    if (cfg_cols == '0) begin
                        r_last_col <= '0;
                    end else if (cfg_cols > mnmf_pkg::COLS_CFG_W'(mnmf_pkg::MAX_COLS)) begin
                        r_last_col <= COL_W'(mnmf_pkg::MAX_COLS - 1);
                    end else begin
                        r_last_col <= COL_W'(cfg_cols - 1'b1);
                    end
                end
                mnmf_pkg::REG_GRID_ROWS: begin
                    if (cfg_rows == '0) begin
                        r_last_row <= '0;
                    end else if (cfg_rows > mnmf_pkg::ROWS_CFG_W'(mnmf_pkg::MAX_ROWS)) begin
                        r_last_row <= ROW_W'(mnmf_pkg::MAX_ROWS - 1);
                    end else begin
                        r_last_row <= ROW_W'(cfg_rows - 1'b1);
                    end
                end
                default: begin
                end
            endcase
            if (cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end
        end else if (in_acc) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mnmf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_pos <= n_pos;
        if (in_acc) begin
            r_r       <= r_row;
            r_cur     <= {i_traversable, i_prob_in};
            r_at_lcol <= (r_col == r_last_col);
            r_at_end  <= (r_col == r_last_col) && (r_row == r_last_row);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_pos     = r_pos;
        rd_en     = 1'b0;
        rd_addr   = r_pos;
        wr_en     = 1'b0;
        shift     = 1'b0;
        flush_col = 1'b0;
        start     = 1'b0;
        out_load  = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            mnmf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    rd_en   = 1'b1;
                    rd_addr = r_col;
                    n_pos   = r_col;
                    n_state = mnmf_pkg::S_READ;
                end
            end
            mnmf_pkg::S_READ: begin
                wr_en = 1'b1;
                shift = 1'b1;
                if (r_r != '0 && r_pos != '0) begin
                    n_job   = mnmf_pkg::JOB_ROW_A;
                    n_state = mnmf_pkg::S_SUM;
                end else if (r_r != '0 && r_at_lcol) begin
                    n_job   = mnmf_pkg::JOB_ROW_B;
                    n_state = mnmf_pkg::S_SUM;
                end else if (r_at_end) begin
                    n_pos   = '0;
                    n_state = mnmf_pkg::S_FRD;
                end else begin
                    n_state = mnmf_pkg::S_IDLE;
                end
            end
            mnmf_pkg::S_SUM: begin
                start   = 1'b1;
                n_state = mnmf_pkg::S_FIX;
            end
            mnmf_pkg::S_FIX: begin
                if (mres.valid && out_free) begin
                    out_load = 1'b1;
                    case (r_job)
                        mnmf_pkg::JOB_ROW_A: begin
                            if (r_at_lcol) begin
                                n_job   = mnmf_pkg::JOB_ROW_B;
                                n_state = mnmf_pkg::S_SUM;
                            end else begin
                                n_state = mnmf_pkg::S_IDLE;
                            end
                        end
                        mnmf_pkg::JOB_ROW_B: begin
                            if (r_at_end) begin
                                n_pos   = '0;
                                n_state = mnmf_pkg::S_FRD;
                            end else begin
                                n_state = mnmf_pkg::S_IDLE;
                            end
                        end
                        mnmf_pkg::JOB_FL_A: begin
                            if (r_pos == r_last_col) begin
                                n_job   = mnmf_pkg::JOB_FL_B;
                                n_state = mnmf_pkg::S_SUM;
                            end else begin
                                n_pos   = r_pos + 1'b1;
                                n_state = mnmf_pkg::S_FRD;
                            end
                        end
                        default: begin
                            n_state = mnmf_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            mnmf_pkg::S_FRD: begin
                rd_en   = 1'b1;
                n_state = mnmf_pkg::S_FSH;
            end
            mnmf_pkg::S_FSH: begin
                shift     = 1'b1;
                flush_col = 1'b1;
                if (r_pos != '0) begin
                    n_job   = mnmf_pkg::JOB_FL_A;
                    n_state = mnmf_pkg::S_SUM;
                end else if (r_pos == r_last_col) begin
                    n_job   = mnmf_pkg::JOB_FL_B;
                    n_state = mnmf_pkg::S_SUM;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = mnmf_pkg::S_FRD;
                end
            end
            default: begin
                n_state = mnmf_pkg::S_IDLE;
            end
        endcase
    end

    // The store write comes in the cycle after the read; the next read of any
    // entry is issued only after the write, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_pos] <= {r_rdata[CELL_W-1:0], r_cur};
        end
    end

    // Window columns run oldest to newest; rows run older, previous, current.
    always_ff @(posedge i_clk) begin
        if (shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_rdata[ENT_W-1:CELL_W];
            r_win[1][2] <= r_rdata[CELL_W-1:0];
            r_win[2][2] <= flush_col ? '0 : r_cur;
        end
    end

    // The edge kinds see the window moved one column left with nothing on
    // the right; flushing uses the two stored rows only.
    assign is_b  = (r_job == mnmf_pkg::JOB_ROW_B) || (r_job == mnmf_pkg::JOB_FL_B);
    assign is_fl = (r_job == mnmf_pkg::JOB_FL_A) || (r_job == mnmf_pkg::JOB_FL_B);
    assign vr[0] = is_fl ? (r_r != '0) : (r_r > ROW_W'(1));
    assign vr[1] = 1'b1;
    assign vr[2] = !is_fl;
    assign vc[0] = is_b ? (r_pos != '0) : (r_pos > COL_W'(1));
    assign vc[1] = 1'b1;
    assign vc[2] = !is_b;

    always_comb begin
        logic [CELL_W-1:0] e;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                if (!is_b) begin
                    e = r_win[i][k];
                end else if (k < 2) begin
                    e = r_win[i][k+1];
                end else begin
                    e = '0;
                end
                nbhd.sel[i*3+k] = vr[i] && vc[k] && e[CELL_W-1];
                nbhd.val[i*3+k] = e[mnmf_pkg::PROB_W-1:0];
            end
        end
    end

    mnmf_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_nbhd  (nbhd),
        .o_res   (mres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oprob <= mres.mean;
            r_orow  <= is_fl ? r_r : r_r - 1'b1;
            r_ocol  <= is_b ? r_pos : r_pos - 1'b1;
            case (r_job)
                mnmf_pkg::JOB_ROW_A: r_olast <= !r_at_lcol;
                mnmf_pkg::JOB_ROW_B: r_olast <= !r_at_end;
                mnmf_pkg::JOB_FL_A:  r_olast <= 1'b0;
                default:             r_olast <= 1'b1;
            endcase
            r_oeof <= (r_job == mnmf_pkg::JOB_FL_B);
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_prob_out     = r_oprob;
    assign o_out_row      = r_orow;
    assign o_out_col      = r_ocol;
    assign o_last_of_run  = r_olast;
    assign o_end_of_frame = r_oeof;

endmodule

[hw/rtl/mnmf_mean.sv]
`timescale 1ns / 1ps

module mnmf_mean (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mnmf_pkg::t_nbhd     i_nbhd,
    output mnmf_pkg::t_mean_res o_res
);

    localparam int QD_W = mnmf_pkg::SUM_W + mnmf_pkg::CNT_W;
    localparam int PR_W = mnmf_pkg::SUM_W + mnmf_pkg::RECIP_W;

    logic                        r_v1;
    logic [mnmf_pkg::SUM_W-1:0]  r_sum1;
    logic [mnmf_pkg::CNT_W-1:0]  r_cnt1;
    logic                        r_ok1;
    logic                        r_v2;
    logic [mnmf_pkg::SUM_W-1:0]  r_sum2;
    logic [mnmf_pkg::CNT_W-1:0]  r_cnt2;
    logic                        r_ok2;
    logic [mnmf_pkg::SUM_W-1:0]  r_q0;

    logic [mnmf_pkg::SUM_W-1:0]  sum;
    logic [mnmf_pkg::CNT_W-1:0]  cnt;
    logic [PR_W-1:0]             prod;
    logic [QD_W-1:0]             qd;
    logic [QD_W-1:0]             rem;
    logic                        inc;
    logic [mnmf_pkg::SUM_W-1:0]  q;

    // Stage one: masked sum as three row sums and a final add.
    always_comb begin
        logic [mnmf_pkg::SUM_W-1:0] row_sum [3];
        for (int i = 0; i < 3; i++) begin
            row_sum[i] = '0;
            for (int k = 0; k < 3; k++) begin
                if (i_nbhd.sel[i*3+k]) begin
                    row_sum[i] = row_sum[i] + mnmf_pkg::SUM_W'(i_nbhd.val[i*3+k]);
                end
            end
        end
        sum = row_sum[0] + row_sum[1] + row_sum[2];
        cnt = mnmf_pkg::CNT_W'($countones(i_nbhd.sel));
    end

    assign prod = {{mnmf_pkg::RECIP_W{1'b0}}, r_sum1}
                * {{mnmf_pkg::SUM_W{1'b0}}, mnmf_pkg::recip(r_cnt1)};

    // The estimate is the quotient or one below it; one compare fixes it.
    assign qd  = {{mnmf_pkg::CNT_W{1'b0}}, r_q0} * {{mnmf_pkg::SUM_W{1'b0}}, r_cnt2};
    assign rem = {{mnmf_pkg::CNT_W{1'b0}}, r_sum2} - qd;
    assign inc = (rem >= {{mnmf_pkg::SUM_W{1'b0}}, r_cnt2});
    assign q   = r_q0 + mnmf_pkg::SUM_W'(inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            if (i_start) begin
                r_v2 <= 1'b0;
            end else if (r_v1) begin
                r_v2 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum1 <= sum;
            r_cnt1 <= cnt;
            r_ok1  <= i_nbhd.sel[4];
        end
        if (r_v1) begin
            r_sum2 <= r_sum1;
            r_cnt2 <= r_cnt1;
            r_ok2  <= r_ok1;
            r_q0   <= prod[mnmf_pkg::FRAC_W +: mnmf_pkg::SUM_W];
        end
    end

    // A cell that is not traversable yields zero.
    assign o_res.valid = r_v2;
    assign o_res.mean  = r_ok2 ? q[mnmf_pkg::PROB_W-1:0] : '0;

endmodule

[hw/rtl/mnmf_checker.sv]
`timescale 1ns / 1ps

module mnmf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [mnmf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input logic [mnmf_pkg::CFG_W-1:0]        i_cfg_data,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic [mnmf_pkg::PROB_W-1:0]       i_prob_in,
    input logic                              i_traversable,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [mnmf_pkg::PROB_W-1:0]       o_prob_out,
    input logic [mnmf_pkg::ROW_W-1:0]        o_out_row,
    input logic [mnmf_pkg::COL_W-1:0]        o_out_col,
    input logic                              o_last_of_run,
    input logic                              o_end_of_frame
);

    // A stalled result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_prob_out) &&
        $stable(o_out_row) && $stable(o_out_col) && $stable(o_last_of_run) &&
        $stable(o_end_of_frame))
        else $error("result changed while stalled");

    // The final result of a frame closes the run of its item.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_last_of_run)
        else $error("end of frame without last of run");

    // Items are taken one at a time: the line store update follows each one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted back to back");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind masked_neighborhood_mean_filter_top mnmf_checker u_mnmf_checker (.*);
